// ===== design/balance_lqr_wheel_torque_defines.svh =====
// Assertion macros shared by the balance controller RTL.
`ifndef BALANCE_LQR_WHEEL_TORQUE_DEFINES_SVH
`define BALANCE_LQR_WHEEL_TORQUE_DEFINES_SVH
`ifndef SYNTHESIS
`define BLWT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("balance_lqr_wheel_torque: check failed");
`define BLWT_IMPLY(lbl, clk, rst_n, ante, cons) \
  `BLWT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`else
`define BLWT_ASSERT(lbl, clk, rst_n, prop)
`define BLWT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/lqrwt_pkg.sv =====
// Shared types and constants of the balance controller.
package lqrwt_pkg;
  localparam int unsigned NUM_W  = 48;  // rate numerator width
  localparam int unsigned DEN_W  = 17;  // step time width
  localparam int unsigned QUOT_W = 64;  // rate quotient width
  localparam int unsigned FRAC_W = 16;  // Q16.16 fraction bits

  localparam logic signed [20:0] YAW_JUMP_LIMIT = 21'sd196608;
  localparam logic signed [20:0] TWO_PI_Q16     = 21'sd411775;

  localparam logic [2:0] REG_GAIN_DISP  = 3'd0;
  localparam logic [2:0] REG_GAIN_SPEED = 3'd1;
  localparam logic [2:0] REG_GAIN_PITCH = 3'd2;
  localparam logic [2:0] REG_GAIN_PRATE = 3'd3;
  localparam logic [2:0] REG_GAIN_YAW   = 3'd4;
  localparam logic [2:0] REG_GAIN_YRATE = 3'd5;
  localparam logic [2:0] REG_RADIUS     = 3'd6;
  localparam logic [2:0] REG_STEP_TIME  = 3'd7;

  typedef struct packed {
    logic                     start;
    logic signed [NUM_W-1:0]  num;
    logic        [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;
endpackage

// ===== design/lqrwt_div.sv =====
// Bit-serial divider: trunc(num * 2^16 / den), one quotient bit per cycle.
module lqrwt_div
  import lqrwt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic [QUOT_W-1:0] dvd_r;
  logic [DEN_W:0]    rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              neg_r;
  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic signed [QUOT_W-1:0] quot_r;

  logic [NUM_W-1:0]  mag;
  logic [DEN_W:0]    rem_sh;
  logic              fits;
  logic [DEN_W:0]    rem_nxt;
  logic [QUOT_W-1:0] dvd_nxt;

  always_comb begin
    mag     = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    rem_sh  = {rem_r[DEN_W-1:0], dvd_r[QUOT_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_nxt = fits ? rem_sh - {1'b0, den_r} : rem_sh;
    dvd_nxt = {dvd_r[QUOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= {mag, {FRAC_W{1'b0}}};
        rem_r  <= '0;
        den_r  <= req.den;
        neg_r  <= req.num[NUM_W-1];
      end else if (busy_r) begin
        // shift in one quotient bit
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= neg_r ? -$signed(dvd_nxt) : $signed(dvd_nxt);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule

// ===== design/balance_lqr_wheel_torque.sv =====
// Top level of the balancing robot LQR wheel torque controller.
// Each item passes three rate divisions in the bit-serial divider (start,
// 64 quotient bits, done), eight shared multiplier steps and the error,
// accumulate and output update steps before out_tvalid. One item at a time:
// no new item is accepted until the result is in the output register.
// Reset (rst_n low, synchronous) loads the default registers and clears state.
`include "balance_lqr_wheel_torque_defines.svh"
module balance_lqr_wheel_torque
  import lqrwt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // encoder_left[31:0], encoder_right[63:32], pitch_angle[82:64],
  // yaw_angle[101:83], speed_target[133:102], yaw_target[165:134], zero pad
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // torque_left[31:0], torque_right[63:32]
  output logic [63:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_MUL_D, S_MUL_TD, S_V_START, S_V_WAIT, S_PR_START, S_PR_WAIT,
    S_Y_START, S_Y_WAIT, S_ERR, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_ACC6,
    S_FIN
  } state_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (x < -64'sh0000_8000_0000_0000) return -48'sh8000_0000_0000;
    return x[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -32'sh8000_0000;
    return x[31:0];
  endfunction

  // configuration registers
  logic signed [31:0] k_r [6];
  logic [30:0]        radius_r;
  logic [16:0]        step_r;

  // tracking state
  logic signed [47:0] td_r, last_d_r, uwy_r;
  logic signed [31:0] last_pitch_r, last_yaw_r;

  // latched item and intermediates
  logic signed [31:0] encl_r, encr_r, spd_r, yawt_r;
  logic signed [18:0] pitch_r, yaw_r;
  logic signed [47:0] d_r, v_r;
  logic signed [31:0] pr_r, yr_r, ed_r, ev_r, ey_r;
  logic signed [55:0] accl_r, accr_r;
  logic signed [65:0] prod_r;
  logic               out_valid_r;
  logic [63:0]        out_data_r;
  state_t             state_r;

  logic signed [32:0] mul_a, mul_b;
  logic [16:0]        t_eff;
  logic signed [55:0] term;
  logic signed [20:0] dy_nxt;
  logic signed [47:0] diff_d_nxt;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign t_eff = (step_r == '0) ? 17'd1 : step_r;
  assign term  = 56'($signed(prod_r[63:16]));

  // yaw step with 2*pi jumps removed, and the saturated displacement step
  always_comb begin
    dy_nxt = 21'(yaw_r) - 21'(last_yaw_r);
    if (dy_nxt > YAW_JUMP_LIMIT) dy_nxt = dy_nxt - TWO_PI_Q16;
    else if (dy_nxt < -YAW_JUMP_LIMIT) dy_nxt = dy_nxt + TWO_PI_Q16;
    diff_d_nxt = sat48(64'(d_r) - 64'(last_d_r));
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_D: begin
        mul_a = 33'(encl_r) + 33'(encr_r);
        mul_b = $signed({2'b00, radius_r});
      end
      S_MUL_TD: begin
        mul_a = 33'(spd_r);
        mul_b = $signed({16'd0, t_eff});
      end
      S_K1: begin mul_a = 33'(k_r[0]); mul_b = 33'(ed_r);    end
      S_K2: begin mul_a = 33'(k_r[1]); mul_b = 33'(ev_r);    end
      S_K3: begin mul_a = 33'(k_r[2]); mul_b = 33'(pitch_r); end
      S_K4: begin mul_a = 33'(k_r[3]); mul_b = 33'(pr_r);    end
      S_K5: begin mul_a = 33'(k_r[4]); mul_b = 33'(ey_r);    end
      S_K6: begin mul_a = 33'(k_r[5]); mul_b = 33'(yr_r);    end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.den   = t_eff;
    div_req.num   = '0;
    case (state_r)
      S_V_START:  begin div_req.start = 1'b1; div_req.num = diff_d_nxt; end
      S_PR_START: begin
        div_req.start = 1'b1;
        div_req.num   = 48'(pitch_r) - 48'(last_pitch_r);
      end
      S_Y_START:  begin div_req.start = 1'b1; div_req.num = 48'(dy_nxt); end
      default:    div_req.start = 1'b0;
    endcase
  end

  lqrwt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      k_r[0]       <= -32'sd146545;
      k_r[1]       <= -32'sd501023;
      k_r[2]       <= -32'sd2312510;
      k_r[3]       <= -32'sd576743;
      k_r[4]       <= 32'sd1981553;
      k_r[5]       <= 32'sd150929;
      radius_r     <= 31'd3277;
      step_r       <= 17'd66;
      td_r         <= '0;
      last_d_r     <= '0;
      uwy_r        <= '0;
      last_pitch_r <= '0;
      last_yaw_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAIN_DISP:  k_r[0]   <= cfg_data;
          REG_GAIN_SPEED: k_r[1]   <= cfg_data;
          REG_GAIN_PITCH: k_r[2]   <= cfg_data;
          REG_GAIN_PRATE: k_r[3]   <= cfg_data;
          REG_GAIN_YAW:   k_r[4]   <= cfg_data;
          REG_GAIN_YRATE: k_r[5]   <= cfg_data;
          REG_RADIUS:     radius_r <= cfg_data[30:0];
          REG_STEP_TIME:  step_r   <= cfg_data[16:0];
          default:        step_r   <= step_r;
        endcase
      end
      // drop a taken result; the final state handles its own cycle
      if (out_valid_r && out_tready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            encl_r  <= in_tdata[31:0];
            encr_r  <= in_tdata[63:32];
            pitch_r <= in_tdata[82:64];
            yaw_r   <= in_tdata[101:83];
            spd_r   <= in_tdata[133:102];
            yawt_r  <= in_tdata[165:134];
            state_r <= S_MUL_D;
          end
        end
        S_MUL_D: state_r <= S_MUL_TD;
        S_MUL_TD: begin
          // floor shift of the mean angle times radius
          d_r     <= prod_r[64:17];
          state_r <= S_V_START;
        end
        S_V_START: begin
          td_r     <= sat48(64'(td_r) + 64'($signed(prod_r[63:16])));
          last_d_r <= d_r;
          state_r  <= S_V_WAIT;
        end
        S_V_WAIT: if (div_rsp.done) begin
          v_r     <= sat48(div_rsp.quot);
          state_r <= S_PR_START;
        end
        S_PR_START: begin
          last_pitch_r <= 32'(pitch_r);
          state_r      <= S_PR_WAIT;
        end
        S_PR_WAIT: if (div_rsp.done) begin
          pr_r    <= sat32(div_rsp.quot);
          state_r <= S_Y_START;
        end
        S_Y_START: begin
          uwy_r      <= sat48(64'(uwy_r) + 64'(dy_nxt));
          last_yaw_r <= 32'(yaw_r);
          state_r    <= S_Y_WAIT;
        end
        S_Y_WAIT: if (div_rsp.done) begin
          yr_r    <= sat32(div_rsp.quot);
          state_r <= S_ERR;
        end
        S_ERR: begin
          ed_r    <= sat32(64'(td_r) - 64'(d_r));
          ev_r    <= sat32(64'(spd_r) - 64'(v_r));
          ey_r    <= sat32(64'(yawt_r) - 64'(uwy_r));
          state_r <= S_K1;
        end
        S_K1: begin
          accl_r  <= '0;
          accr_r  <= '0;
          state_r <= S_K2;
        end
        S_K2, S_K3, S_K4, S_K5: begin
          // common terms go to both wheels
          accl_r  <= accl_r + term;
          accr_r  <= accr_r + term;
          state_r <= state_t'(state_r + 1'b1);
        end
        S_K6: begin
          accl_r  <= accl_r - term;
          accr_r  <= accr_r + term;
          state_r <= S_ACC6;
        end
        S_ACC6: begin
          accl_r  <= accl_r + term;
          accr_r  <= accr_r - term;
          state_r <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {sat32(64'(accr_r)), sat32(64'(accl_r))};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BLWT_IMPLY(a_div_done_waiting, clk, rst_n, div_rsp.done,
    state_r == S_V_WAIT || state_r == S_PR_WAIT || state_r == S_Y_WAIT)
  `BLWT_IMPLY(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, ##1 !in_tready)
  `BLWT_IMPLY(a_result_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r == S_FIN))
endmodule

// ===== tb/sv/balance_lqr_wheel_torque_checker.sv =====
// Checker for the wheel torque controller: it predicts the torques and compares them.
module balance_lqr_wheel_torque_checker
  import lqrwt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [167:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           torques_pending
);

  longint k_disp, k_speed, k_pitch, k_prate, k_yaw, k_yrate, radius, step_t;
  longint tgt_dist, prev_dist, prev_pitch, yaw_acc, prev_yaw;
  logic [63:0] torque_q[$];

  function automatic longint clamp(longint x, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // Truncating divide of a 48-bit clamped difference, scaled to Q16.16.
  function automatic longint per_step(longint diff, longint t);
    return (clamp(diff, 48) * 65536) / t;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what,
             $signed(got), $signed(want), $realtime);
    fail_count++;
  endtask

  // Advance the tracking state by one tick and queue the torque pair.
  task automatic predict_torques(input logic [167:0] d);
    longint encl, encr, pitch, yaw, spd, yaw_t, t;
    longint disp, v, pr, dy, yr, ed, ev, ey, common, t5, t6, left, right;
    encl  = longint'($signed(d[31:0]));
    encr  = longint'($signed(d[63:32]));
    pitch = longint'($signed(d[82:64]));
    yaw   = longint'($signed(d[101:83]));
    spd   = longint'($signed(d[133:102]));
    yaw_t = longint'($signed(d[165:134]));
    t = (step_t == 0) ? 1 : step_t;

    disp = ((encl + encr) * radius) >>> 17;
    tgt_dist = clamp(tgt_dist + ((spd * t) >>> 16), 48);
    v  = clamp(per_step(disp - prev_dist, t), 48);
    pr = clamp(per_step(pitch - prev_pitch, t), 32);

    // Remove a full turn when the raw yaw wraps across +-pi.
    dy = yaw - prev_yaw;
    if (dy > longint'(YAW_JUMP_LIMIT)) dy -= longint'(TWO_PI_Q16);
    else if (dy < -longint'(YAW_JUMP_LIMIT)) dy += longint'(TWO_PI_Q16);
    yaw_acc = clamp(yaw_acc + dy, 48);
    yr = clamp(per_step(dy, t), 32);

    ed = clamp(tgt_dist - disp, 32);
    ev = clamp(spd - v, 32);
    ey = clamp(yaw_t - yaw_acc, 32);

    common = ((k_disp * ed) >>> 16) + ((k_speed * ev) >>> 16)
           + ((k_pitch * pitch) >>> 16) + ((k_prate * pr) >>> 16);
    t5 = (k_yaw * ey) >>> 16;
    t6 = (k_yrate * yr) >>> 16;
    left  = clamp(common - t5 + t6, 32);
    right = clamp(common + t5 - t6, 32);

    prev_dist  = disp;
    prev_pitch = pitch;
    prev_yaw   = yaw;
    torque_q.push_back({right[31:0], left[31:0]});
  endtask

  initial begin
    fail_count = 0;
    torques_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      k_disp  = -146545;
      k_speed = -501023;
      k_pitch = -2312510;
      k_prate = -576743;
      k_yaw   = 1981553;
      k_yrate = 150929;
      radius  = 3277;
      step_t  = 66;
      tgt_dist = 0; prev_dist = 0; prev_pitch = 0; yaw_acc = 0; prev_yaw = 0;
      torque_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_DISP:  k_disp  = longint'($signed(cfg_data));
          REG_GAIN_SPEED: k_speed = longint'($signed(cfg_data));
          REG_GAIN_PITCH: k_pitch = longint'($signed(cfg_data));
          REG_GAIN_PRATE: k_prate = longint'($signed(cfg_data));
          REG_GAIN_YAW:   k_yaw   = longint'($signed(cfg_data));
          REG_GAIN_YRATE: k_yrate = longint'($signed(cfg_data));
          REG_RADIUS:     radius  = longint'({33'd0, cfg_data[30:0]});
          REG_STEP_TIME:  step_t  = longint'({47'd0, cfg_data[16:0]});
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_torques(in_tdata);
      if (out_tvalid && out_tready) begin
        if (torque_q.size() == 0) begin
          report_mismatch("unexpected torque item", out_tdata[31:0], 32'd0);
        end else begin
          if (out_tdata[31:0] !== torque_q[0][31:0])
            report_mismatch("torque_left", out_tdata[31:0], torque_q[0][31:0]);
          if (out_tdata[63:32] !== torque_q[0][63:32])
            report_mismatch("torque_right", out_tdata[63:32], torque_q[0][63:32]);
          void'(torque_q.pop_front());
        end
      end
    end
    torques_pending = torque_q.size();
  end

endmodule

// ===== tb/sv/balance_lqr_wheel_torque_tb.sv =====
// Testbench top for the wheel torque controller: stimulus, stalls and verdict.
module balance_lqr_wheel_torque_tb;
  import lqrwt_pkg::*;

  localparam int ANGLE_MAX = 205887;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // encoder_left[31:0], encoder_right[63:32], pitch_angle[82:64],
  // yaw_angle[101:83], speed_target[133:102], yaw_target[165:134], zero pad
  logic [167:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // torque_left[31:0], torque_right[63:32]
  logic [63:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  int fail_count;
  int torques_pending;
  int send_gap_pct = 0;   // chance in percent that the sender idles a cycle
  int recv_stall_pct = 0; // chance in percent that the receiver stalls a cycle

  always #4 clk = ~clk;

  balance_lqr_wheel_torque DUT (.*);

  balance_lqr_wheel_torque_checker u_checker (.*);

  // Receiver: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one sensor tick; hold until accepted. Valid stays high afterwards
  // so back-to-back ticks never toggle it within one step.
  task automatic send_tick(input logic signed [31:0] encl, input logic signed [31:0] encr,
                           input int pitch, input int yaw,
                           input logic signed [31:0] spd, input logic signed [31:0] yaw_t);
    logic [18:0] p19, y19;
    p19 = pitch[18:0];
    y19 = yaw[18:0];
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, yaw_t, spd, y19, p19, encr, encl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every torque item has come back.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (torques_pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] kd, input logic [31:0] kv,
                           input logic [31:0] kp, input logic [31:0] kpr,
                           input logic [31:0] ky, input logic [31:0] kyr,
                           input logic [31:0] rad, input logic [31:0] st);
    write_reg(REG_GAIN_DISP, kd);
    write_reg(REG_GAIN_SPEED, kv);
    write_reg(REG_GAIN_PITCH, kp);
    write_reg(REG_GAIN_PRATE, kpr);
    write_reg(REG_GAIN_YAW, ky);
    write_reg(REG_GAIN_YRATE, kyr);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_STEP_TIME, st);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int any_angle();
    return $urandom_range(2 * ANGLE_MAX) - ANGLE_MAX;
  endfunction

  // Mostly a plausible drive: slowly moving encoders and yaw, small random pitch, with yaw
  // wrapping across +-pi now and then; the rest is full-range noise.
  task automatic random_ticks(input int count);
    logic signed [31:0] enc = 0;
    int pitch = 0, yaw = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) begin
        enc   += $signed($urandom_range(4000)) - 2000;
        pitch  = $urandom_range(20000) - 10000;
        yaw   += $signed($urandom_range(40000)) - 20000;
        if (yaw > ANGLE_MAX) yaw -= 2 * ANGLE_MAX;
        if (yaw < -ANGLE_MAX) yaw += 2 * ANGLE_MAX;
        send_tick(enc, enc + $signed($urandom_range(200)) - 100, pitch, yaw,
                  $signed($urandom_range(131072)) - 65536,
                  $signed($urandom_range(800000)) - 400000);
      end else begin
        send_tick($urandom, $urandom, any_angle(), any_angle(), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 1: default registers; sender idles rarely, receiver often.
    send_gap_pct = 8;
    recv_stall_pct = 56;
    send_tick(32'sh7fffffff, 32'sh7fffffff, ANGLE_MAX, ANGLE_MAX,
              32'sh7fffffff, 32'sh7fffffff);
    // Yaw wraps from +pi to -pi, and back the other way.
    send_tick(-32'sh80000000, -32'sh80000000, -ANGLE_MAX, -ANGLE_MAX,
              -32'sh80000000, -32'sh80000000);
    send_tick(0, 0, 0, ANGLE_MAX, 0, 0);
    send_tick(0, 0, 0, -ANGLE_MAX, 0, 0);
    // Steps right at and just past the jump threshold.
    send_tick(0, 0, 0, -ANGLE_MAX + 196608, 0, 0);
    send_tick(0, 0, 0, -ANGLE_MAX + 196608 + 196609 - 196608 - 1, 0, 0);
    send_tick(0, 0, 0, 196609 - ANGLE_MAX - 1 + 196609, 0, 0);
    send_tick(32'sh7fffffff, -32'sh80000000, ANGLE_MAX, 0, 1, -1);
    send_tick(-1, -1, -1, -1, -1, -1);
    send_tick(0, 0, 0, 0, 0, 0);
    random_ticks(200);
    drain();

    // Phase 2: largest gains and radius, step time of 65536.
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0001_0000);
    send_tick(32'sh7fffffff, 32'sh7fffffff, ANGLE_MAX, ANGLE_MAX,
              32'sh7fffffff, 32'sh7fffffff);
    send_tick(-32'sh80000000, -32'sh80000000, -ANGLE_MAX, -ANGLE_MAX,
              -32'sh80000000, -32'sh80000000);
    random_ticks(200);
    drain();

    // Phase 3: most negative gains, radius of one, zero step time (taken as
    // one); sender idles often, receiver rarely.
    send_gap_pct = 56;
    recv_stall_pct = 8;
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h00000001, 32'h0);
    send_tick(32'sh7fffffff, 32'sh7fffffff, ANGLE_MAX, ANGLE_MAX,
              32'sh7fffffff, -32'sh80000000);
    send_tick(-32'sh80000000, -32'sh80000000, -ANGLE_MAX, -ANGLE_MAX,
              -32'sh80000000, 32'sh7fffffff);
    random_ticks(200);
    drain();

    // Phase 4: step time of one, random gains and radius.
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(60000, 1), 32'd1);
    random_ticks(200);
    drain();

    // Phase 5: random registers, no idling on either side.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom_range(65536, 1));
    random_ticks(280);
    drain();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
